// ===== design/utf8ca_pkg.sv =====
// utf8ca_pkg: constants and helper functions for the utf-8 character assembler
// no dependencies; imported by utf8_char_assembler
`default_nettype none

package utf8ca_pkg;

  // longest sequence the gather buffer holds
  localparam int unsigned MaxSeqBytes = 6;
  localparam int unsigned CountW      = 3;
  localparam int unsigned NeedW       = 4;

  typedef logic [7:0]        byte_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [NeedW-1:0]  need_t;

  localparam count_t SeqFullCount = count_t'(MaxSeqBytes);
  localparam byte_t  NulByte      = 8'h00;
  localparam byte_t  NewlineByte  = 8'h0a;

  // overlong-form masks on the first and second byte
  localparam byte_t Len2MaskB0 = 8'h1e;
  localparam byte_t Len3MaskB0 = 8'h0f;
  localparam byte_t Len3MaskB1 = 8'h20;
  localparam byte_t Len4MaskB0 = 8'h07;
  localparam byte_t Len4MaskB1 = 8'h30;
  localparam byte_t Len5MaskB0 = 8'h03;
  localparam byte_t Len5MaskB1 = 8'h38;
  localparam byte_t Len6MaskB0 = 8'h01;
  localparam byte_t Len6MaskB1 = 8'h3c;

  // run of leading ones, a plain ascii byte counts as one
  function automatic need_t lead_ones(input byte_t b);
    need_t n;
    if      (!b[7]) n = 4'd1;
    else if (!b[6]) n = 4'd1;
    else if (!b[5]) n = 4'd2;
    else if (!b[4]) n = 4'd3;
    else if (!b[3]) n = 4'd4;
    else if (!b[2]) n = 4'd5;
    else if (!b[1]) n = 4'd6;
    else if (!b[0]) n = 4'd7;
    else            n = 4'd8;
    return n;
  endfunction

  // shortest-form check for a complete sequence
  function automatic logic form_ok(input count_t len, input byte_t b0, input byte_t b1);
    logic ok;
    case (len)
      3'd1: ok = 1'b1;
      3'd2: ok = |(b0 & Len2MaskB0);
      3'd3: ok = |(b0 & Len3MaskB0) || |(b1 & Len3MaskB1);
      3'd4: ok = |(b0 & Len4MaskB0) || |(b1 & Len4MaskB1);
      3'd5: ok = |(b0 & Len5MaskB0) || |(b1 & Len5MaskB1);
      3'd6: ok = |(b0 & Len6MaskB0) || |(b1 & Len6MaskB1);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

`default_nettype wire

// ===== design/utf8_char_assembler.sv =====
// utf8_char_assembler: gathers a byte stream into utf-8 characters of up to six bytes
// depends on utf8ca_pkg (types, overlong masks, lead_ones, form_ok)
//
// usage
//   input channel: one byte per word on in_byte_in, taken when in_valid is high
//   and in_stall is low
//   output channel: one character per word (bytes, length, newline flag, display
//   width), taken when out_valid is high and out_stall is low
//   a byte first lands in an input register; from there it is merged with the
//   gather buffer and, if it completes a valid character, the character is loaded
//   into the output register
//   throughput is one byte per cycle while the receiver does not stall; the single-pass
//   decode between the input register and the output register sets that figure
//   nul bytes, overlong forms and runs that cannot complete (0xfe/0xff leads) are
//   dropped silently and produce no word
//   when the receiver stalls, the output register holds its word and the input
//   register takes one more byte before in_stall rises
//   reset (rst_n low, synchronous) empties both registers and the gather count
`default_nettype none

module utf8_char_assembler (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  utf8ca_pkg::byte_t    in_byte_in,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [47:0]          out_char_bytes,
  output utf8ca_pkg::count_t   out_char_length,
  output logic                 out_newline_flag,
  output logic [1:0]           out_display_width
);
  import utf8ca_pkg::*;

  // input register
  logic   s1_valid_r;
  byte_t  s1_byte_r;

  // gather state: bytes beyond the count are never read
  byte_t  gather_r [MaxSeqBytes];
  count_t cnt_r, cnt_nxt;

  // output register
  logic        out_valid_r;
  logic [47:0] char_bytes_r, char_bytes_nxt;
  count_t      char_length_r;
  logic        newline_r, newline_nxt;
  logic [1:0]  width_r, width_nxt;

  logic   s2_free, s1_fire, in_fire;
  logic   seq_full, nul_drop, emit, store_byte;
  count_t have;
  byte_t  first_b, second_b;
  need_t  need;

  // handshake: the output register frees when empty or being taken
  assign s2_free  = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && s2_free;
  assign in_stall = s1_valid_r && !s2_free;
  assign in_fire  = in_valid && !in_stall;

  // decode of the pending byte against the gather buffer
  always_comb begin
    seq_full = (cnt_r == SeqFullCount);
    have     = cnt_r + 3'd1;
    first_b  = (cnt_r == 3'd0) ? s1_byte_r : gather_r[0];
    second_b = (cnt_r == 3'd1) ? s1_byte_r : gather_r[1];
    need     = lead_ones(first_b);
    nul_drop = (cnt_r == 3'd0) && (s1_byte_r == NulByte);

    emit       = 1'b0;
    store_byte = 1'b0;
    cnt_nxt    = 3'd0;
    if (seq_full || nul_drop) begin
      // seventh byte of a lead that never completes, or a nul: drop all
      cnt_nxt = 3'd0;
    end else if (need > {1'b0, have}) begin
      // still gathering
      store_byte = 1'b1;
      cnt_nxt    = have;
    end else if ((need == {1'b0, have}) && form_ok(have, first_b, second_b)) begin
      emit = 1'b1;
    end
  end

  // assembled character word, bytes past the length stay zero
  always_comb begin
    for (int i = 0; i < MaxSeqBytes; i++) begin
      if (count_t'(i) < cnt_r) begin
        char_bytes_nxt[8*i +: 8] = gather_r[i];
      end else if (count_t'(i) == cnt_r) begin
        char_bytes_nxt[8*i +: 8] = s1_byte_r;
      end else begin
        char_bytes_nxt[8*i +: 8] = 8'h00;
      end
    end
    newline_nxt = (have == 3'd1) && (first_b == NewlineByte);
    width_nxt   = (have > 3'd1) ? 2'd2 : 2'd1;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_byte_in;
    end
  end

  // gather count and buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else if (s1_fire) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && store_byte) begin
      gather_r[cnt_r] <= s1_byte_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_free) begin
      out_valid_r <= s1_valid_r && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      char_bytes_r  <= char_bytes_nxt;
      char_length_r <= have;
      newline_r     <= newline_nxt;
      width_r       <= width_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_char_bytes    = char_bytes_r;
  assign out_char_length   = char_length_r;
  assign out_newline_flag  = newline_r;
  assign out_display_width = width_r;

`ifndef SYNTH
  // gather count never passes the buffer depth
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= SeqFullCount)
    else $error("gather count out of range");

  // an emitted character always leaves the gather buffer empty
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && emit) |=> (cnt_r == 3'd0))
    else $error("gather count not cleared after emit");

  // a newline word is the single byte 0x0a
  a_newline_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && newline_r) |-> (char_length_r == 3'd1 &&
      char_bytes_r[7:0] == NewlineByte))
    else $error("newline flag on a non-newline word");

  // display width follows the length
  a_width_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((char_length_r == 3'd1) == (width_r == 2'd1)) &&
      char_length_r != 3'd0 && char_length_r <= SeqFullCount)
    else $error("display width does not match length");

  // stall on input only while a byte is held
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with nothing pending");
`endif

endmodule

`default_nettype wire

// ===== verif/utf8_char_assembler_tb.sv =====
// utf8_char_assembler_tb: self-checking bench for the utf-8 character assembler
// drives a byte stream with random gaps and output back-pressure, predicts every character
// depends on utf8ca_pkg and utf8_char_assembler
`timescale 1ns / 1ps

module utf8_char_assembler_tb;
  import utf8ca_pkg::*;

  // one emitted character as seen on the output channel
  typedef struct packed {
    logic [47:0] bytes;
    count_t      len;
    logic        nl;
    logic [1:0]  width;
  } char_t;

  // one row of the directed table: byte to send, and optionally a typed-in outcome
  typedef struct {
    byte_t b;
    bit    typed;
    bit    emits;
    char_t c;
  } row_t;

  localparam char_t NoChar = '0;
  localparam int unsigned DirRows = 26;
  localparam int unsigned ByteTarget = 1950;
  // random phase: no idling on either side inside this window of sent bytes
  localparam int unsigned QuietFrom = 700;
  localparam int unsigned QuietTo = 1000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  byte_t       in_byte_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [47:0] out_char_bytes;
  count_t      out_char_length;
  logic        out_newline_flag;
  logic [1:0]  out_display_width;

  // predictor state: bytes gathered so far and how many
  byte_t       gather_q [MaxSeqBytes];
  int unsigned gather_n;

  char_t       pending_chars [$];
  int unsigned sent_count = 0;
  int unsigned mismatch_count = 0;
  bit          quiet = 1'b0;
  bit          drained_mid = 1'b0;

  // directed table: extremes, nul, stray continuation, overlong forms, the
  // longest legal forms and a 0xff lead that swallows six bytes plus a seventh
  row_t dir_rows [DirRows] = '{
    // nul straight after reset is dropped
    '{8'h00, 1'b1, 1'b0, NoChar},
    // newline, the only character with the flag set
    '{8'h0a, 1'b1, 1'b1, '{48'h0a, 3'd1, 1'b1, 2'd1}},
    // highest ascii byte
    '{8'h7f, 1'b1, 1'b1, '{48'h7f, 3'd1, 1'b0, 2'd1}},
    // stray continuation goes out as a one-byte character
    '{8'h80, 1'b1, 1'b1, '{48'h80, 3'd1, 1'b0, 2'd1}},
    // overlong two-byte form
    '{8'hc0, 1'b1, 1'b0, NoChar},
    '{8'h80, 1'b1, 1'b0, NoChar},
    // overlong three-byte form
    '{8'he0, 1'b1, 1'b0, NoChar},
    '{8'h80, 1'b1, 1'b0, NoChar},
    '{8'h80, 1'b1, 1'b0, NoChar},
    // top of the four-byte range
    '{8'hf4, 1'b0, 1'b0, NoChar},
    '{8'h8f, 1'b0, 1'b0, NoChar},
    '{8'hbf, 1'b0, 1'b0, NoChar},
    '{8'hbf, 1'b0, 1'b0, NoChar},
    // shortest legal six-byte form
    '{8'hfc, 1'b0, 1'b0, NoChar},
    '{8'h84, 1'b0, 1'b0, NoChar},
    '{8'h80, 1'b0, 1'b0, NoChar},
    '{8'h80, 1'b0, 1'b0, NoChar},
    '{8'h80, 1'b0, 1'b0, NoChar},
    '{8'h80, 1'b0, 1'b0, NoChar},
    // eight leading ones never complete, the seventh byte goes with them
    '{8'hff, 1'b1, 1'b0, NoChar},
    '{8'h80, 1'b1, 1'b0, NoChar},
    '{8'h80, 1'b1, 1'b0, NoChar},
    '{8'h80, 1'b1, 1'b0, NoChar},
    '{8'h80, 1'b1, 1'b0, NoChar},
    '{8'h80, 1'b1, 1'b0, NoChar},
    '{8'h41, 1'b1, 1'b0, NoChar}
  };

  utf8_char_assembler uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte_in       (in_byte_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char_bytes   (out_char_bytes),
    .out_char_length  (out_char_length),
    .out_newline_flag (out_newline_flag),
    .out_display_width(out_display_width)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void flush_gather();
    foreach (gather_q[i]) gather_q[i] = '0;
    gather_n = 0;
  endfunction

  // expected length from the lead byte; plain ascii counts as one
  function automatic int unsigned seq_len_of(byte_t b);
    int unsigned n;
    n = 0;
    while (n < 8 && b[7 - n]) n++;
    return (n == 0) ? 1 : n;
  endfunction

  // predict the outcome of one accepted byte and advance the gather state
  function automatic void assemble_byte(input byte_t b, output bit emits, output char_t c);
    int unsigned have;
    int unsigned need;
    bit          shortest;
    byte_t       b0;
    byte_t       b1;
    emits = 1'b0;
    c = NoChar;
    // a seventh byte can only arrive behind a 0xfe/0xff lead
    if (gather_n >= MaxSeqBytes) begin
      flush_gather();
      return;
    end
    gather_q[gather_n] = b;
    have = gather_n + 1;
    if (have == 1 && b == NulByte) begin
      flush_gather();
      return;
    end
    need = seq_len_of(gather_q[0]);
    if (need > have) begin
      gather_n = have;
      return;
    end
    b0 = gather_q[0];
    b1 = gather_q[1];
    case (have)
      1: shortest = 1'b1;
      2: shortest = (b0 & Len2MaskB0) != 0;
      3: shortest = (b0 & Len3MaskB0) != 0 || (b1 & Len3MaskB1) != 0;
      4: shortest = (b0 & Len4MaskB0) != 0 || (b1 & Len4MaskB1) != 0;
      5: shortest = (b0 & Len5MaskB0) != 0 || (b1 & Len5MaskB1) != 0;
      6: shortest = (b0 & Len6MaskB0) != 0 || (b1 & Len6MaskB1) != 0;
      default: shortest = 1'b0;
    endcase
    if (need == have && shortest) begin
      for (int unsigned i = 0; i < have; i++) c.bytes[8*i +: 8] = gather_q[i];
      c.len = count_t'(have);
      c.nl = (have == 1 && b0 == NewlineByte);
      c.width = (have > 1) ? 2'd2 : 2'd1;
      emits = 1'b1;
    end
    flush_gather();
  endfunction

  // present one byte, hold it until taken, then record what it should produce
  task automatic send_byte(input byte_t b, input bit typed, input bit typed_emits,
                           input char_t typed_c);
    bit    emits;
    char_t c;
    // random gap before the word, never while the quiet window is on
    while (!quiet && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_in <= b;
    do @(posedge clk); while (in_stall);
    assemble_byte(b, emits, c);
    // typed rows override the prediction, the state still advances
    if (typed) begin
      emits = typed_emits;
      c = typed_c;
    end
    if (emits) pending_chars.push_back(c);
    sent_count++;
  endtask

  // sender holds off until every expected character has come out
  task automatic drain_pending();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    // the input and output registers plus margin, so a dropped sequence has settled too
    repeat (4) @(posedge clk);
  endtask

  // one random character: mostly well-formed with random payload, plus
  // noise, nul, stray continuations, never-ending leads, overlong and cut-short runs
  task automatic send_random_char();
    byte_t       seq [8];
    byte_t       lead_mask;
    int unsigned n;
    int unsigned kind;
    bit          overlong;
    kind = $urandom_range(99);
    n = 0;
    if (kind < 10) begin
      n = $urandom_range(1, 3);
      for (int unsigned k = 0; k < n; k++) seq[k] = byte_t'($urandom);
    end else if (kind < 14) begin
      seq[0] = $urandom_range(1) ? 8'hff : 8'hfe;
      for (int unsigned k = 1; k < 7; k++) seq[k] = byte_t'($urandom);
      n = 7;
    end else if (kind < 18) begin
      seq[0] = NulByte;
      n = 1;
    end else if (kind < 22) begin
      seq[0] = 8'h80 | byte_t'($urandom_range(63));
      n = 1;
    end else begin
      n = ($urandom_range(99) < 30) ? 1 : $urandom_range(2, MaxSeqBytes);
      overlong = (n > 1) && ($urandom_range(99) < 20);
      if (n == 1) begin
        seq[0] = byte_t'($urandom_range(1, 127));
      end else begin
        lead_mask = 8'hff >> n;
        seq[0] = ~lead_mask | (byte_t'($urandom) & (lead_mask >> 1));
      end
      for (int unsigned k = 1; k < n; k++) seq[k] = 8'h80 | byte_t'($urandom_range(63));
      // clear every payload bit the shortest-form test looks at
      if (overlong) begin
        seq[0] = ~(8'hff >> n);
        seq[1] = 8'h80;
      end
      // cut short: the next character's lead lands as a continuation
      if (kind < 28 && n > 1) n = $urandom_range(1, n - 1);
    end
    for (int unsigned k = 0; k < n; k++) send_byte(seq[k], 1'b0, 1'b0, NoChar);
  endtask

  // receiver back-pressure, off inside the quiet window
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 34);
  end

  // compare each taken output word with the oldest expected character
  always @(posedge clk) begin
    char_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected output word: char_bytes %h length %0d",
               out_char_bytes, out_char_length);
        mismatch_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_char_bytes !== want.bytes) begin
          $error("char_bytes: expected %h, actual %h", want.bytes, out_char_bytes);
          mismatch_count++;
        end
        if (out_char_length !== want.len) begin
          $error("char_length: expected %0d, actual %0d", want.len, out_char_length);
          mismatch_count++;
        end
        if (out_newline_flag !== want.nl) begin
          $error("newline_flag: expected %b, actual %b", want.nl, out_newline_flag);
          mismatch_count++;
        end
        if (out_display_width !== want.width) begin
          $error("display_width: expected %0d, actual %0d", want.width, out_display_width);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    flush_gather();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].typed,
                                    dir_rows[i].emits, dir_rows[i].c);
    // idle with nothing in flight between directed and random traffic
    drain_pending();

    while (sent_count < ByteTarget) begin
      quiet = (sent_count >= QuietFrom && sent_count < QuietTo);
      if (!drained_mid && sent_count >= QuietTo) begin
        drain_pending();
        drained_mid = 1'b1;
      end
      send_random_char();
    end
    quiet = 1'b0;

    drain_pending();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/utf8ca_pkg.sv
design/utf8_char_assembler.sv
verif/utf8_char_assembler_tb.sv
